// ===== design/sitdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared package
// Widths, character codes, state encoding and cell control for the core.
// ----------------------------------------------------------------------------
package sitdt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int NUM_DIGITS = (VALUE_BITS * 3) / 10 + 1;
    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHAR_W     = 6;
    localparam int OUT_DATA_W = 8;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [3:0]            t_digit;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic rotate;
    } t_cell_ctrl;

endpackage

// ===== design/sitdt_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal text: BCD digit cell
// Holds one decimal digit. Shifts in one binary bit with add-3 correction,
// or takes its lower neighbour's digit to move the digits upwards, or clears.
// ----------------------------------------------------------------------------
module sitdt_bcd_cell
    import sitdt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_bit,
    input  t_digit     i_digit,
    output logic       o_bit,
    output t_digit     o_digit
);

    t_digit r_digit;
    t_digit n_digit;
    t_digit adj;

    always_comb begin
        adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {adj[2:0], i_bit};
        end else if (i_ctrl.rotate) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = adj[3];
    assign o_digit = r_digit;

endmodule

// ===== design/signed_int_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal text: top level
// Steps: shift-and-add-3 conversion of the magnitude, then leading zeros are
// dropped (all but the last digit) before the first character is offered.
// Throughput: one character per ready cycle, '-' first if negative; the next item
// is accepted in the cycle after the last character; the conversion shifts in
// one bit per cycle.
// Reset (synchronous, active low) returns the controller to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_core
    import sitdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [VALUE_BITS-1:0] value
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [5:0] character
    output logic                  o_m_axis_tlast
);

    t_state                 r_state;
    t_state                 n_state;
    t_value                 r_mag;
    logic                   r_neg;
    logic [BIT_CNT_W-1:0]   r_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_left;
    t_value                 raw;
    t_cell_ctrl             cell_ctrl;
    logic                   in_acc;
    logic                   out_acc;
    logic                   top_zero;
    t_digit                 top_digit;
    logic [CHAR_W-1:0]      out_char;
    logic [NUM_DIGITS:0]    bit_chain;
    t_digit                 digit_chain [NUM_DIGITS+1];

    assign raw       = i_s_axis_tdata[VALUE_BITS-1:0];
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc   = o_m_axis_tvalid && i_m_axis_tready;
    assign top_digit = digit_chain[NUM_DIGITS];
    assign top_zero  = (top_digit == 4'd0);

    assign bit_chain[0]   = r_mag[VALUE_BITS-1];
    assign digit_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            sitdt_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl),
                .i_bit   (bit_chain[g]),
                .i_digit (digit_chain[g]),
                .o_bit   (bit_chain[g+1]),
                .o_digit (digit_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (r_bit_cnt == BIT_CNT_W'(1)) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!(top_zero && r_left > DIG_CNT_W'(1))) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_m_axis_tready) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_m_axis_tready && r_left == DIG_CNT_W'(1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cell_ctrl       = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        o_m_axis_tlast  = 1'b0;
        out_char        = CHAR_ZERO + {2'b00, top_digit};
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                cell_ctrl.clear = i_s_axis_tvalid;
            end
            ST_CONVERT: begin
                cell_ctrl.dabble = 1'b1;
            end
            ST_SKIP: begin
                cell_ctrl.rotate = top_zero && (r_left > DIG_CNT_W'(1));
            end
            ST_SIGN: begin
                o_m_axis_tvalid = 1'b1;
                out_char        = CHAR_MINUS;
            end
            ST_EMIT: begin
                o_m_axis_tvalid  = 1'b1;
                o_m_axis_tlast   = (r_left == DIG_CNT_W'(1));
                cell_ctrl.rotate = i_m_axis_tready;
            end
            default: begin
                cell_ctrl = '0;
            end
        endcase
    end

    assign o_m_axis_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, out_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg     <= raw[VALUE_BITS-1];
            r_mag     <= raw[VALUE_BITS-1] ? t_value'(~raw + t_value'(1)) : raw;
            r_bit_cnt <= BIT_CNT_W'(VALUE_BITS);
            r_left    <= DIG_CNT_W'(NUM_DIGITS);
        end else if (r_state == ST_CONVERT) begin
            r_mag     <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
        end else if (cell_ctrl.rotate) begin
            r_left    <= r_left - DIG_CNT_W'(1);
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_CONVERT) && (r_bit_cnt == BIT_CNT_W'(VALUE_BITS)))
        else $error("conversion did not start after an accepted item");

    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("minus sign offered for a non-negative value");

    a_digit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (top_digit <= 4'd9))
        else $error("digit cell holds a non-decimal code");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> (!top_zero || r_left == DIG_CNT_W'(1)))
        else $error("leading zero left after suppression");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("block not ready after the last character");

endmodule
